### hdl/pkop_pkg.sv
// Package for the per-key ordinal predictor: transaction structs, opcodes,
// job descriptors passed from front to back, and state machine encodings.
// No dependencies.
package pkop_pkg;

	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int KEY_SLOTS_DEF     = 64;
	localparam int KEY_W_MAX         = 10;  // keys up to 1024 slots
	localparam int SLOT_W_MAX        = 6;   // ring up to 64 entries
	localparam int MAX_OUT           = 5;
	localparam int STRONG_COUNT      = 5;
	localparam int WEAK_COUNT        = 3;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [15:0] NOT_FOUND = 16'hFFFF;

	// Opcodes of the command port
	localparam logic [1:0] OP_RECORD   = 2'd0;
	localparam logic [1:0] OP_QUERY    = 2'd1;
	localparam logic [1:0] OP_DISABLE  = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;  // ignored, no result

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  key_index;
		logic [15:0] ordinal;
	} cmd_t;

	typedef struct packed {
		logic [15:0] candidate;
		logic        none_found;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		JOB_RECORD,
		JOB_QUERY,
		JOB_NONE
	} job_kind_t;

	// slot holds the ring write slot for a record, the write pointer for a query
	typedef struct packed {
		job_kind_t               kind;
		logic [KEY_W_MAX-1:0]    key;
		logic [SLOT_W_MAX-1:0]   slot;
		logic                    full;
		logic [15:0]             ordinal;
	} job_t;

	typedef enum logic [1:0] {
		F_CLEAR,
		F_IDLE,
		F_ACT
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_CMP,
		B_EVAL,
		B_EMIT
	} back_state_t;

endpackage

### hdl/per_key_ordinal_predictor_core.sv
// Top level of the per-key ordinal predictor: front end, job queue, back end.
// Depends on pkop_pkg, pkop_front, pkop_queue, pkop_back.
//
//   channel   ports                    handshake
//   command   start, busy, cmd         taken when start && !busy
//   result    strobe, result           one cycle per result, no backpressure
//
// After reset the key metadata is cleared, with busy high.
// Record and disable pass through F_ACT in the front end; busy holds while
// a record or query waits in F_ACT on a full job queue. A query loads the
// key's ring through the single read port, then visits B_CMP and B_EVAL for
// each ring slot, then emits one result per cycle, on consecutive cycles.
module per_key_ordinal_predictor_core #(
	parameter int HISTORY_DEPTH = pkop_pkg::HISTORY_DEPTH_DEF,
	parameter int KEY_SLOTS     = pkop_pkg::KEY_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pkop_pkg::cmd_t    cmd,
	output logic              busy,
	output pkop_pkg::result_t result,
	output logic              strobe
);
	import pkop_pkg::*;

	job_t push_job, head_job;
	logic push, pop, q_full, q_empty;

	pkop_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .KEY_SLOTS(KEY_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.job(push_job), .push(push), .q_full(q_full)
	);

	pkop_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_job(push_job), .pop(pop),
		.head(head_job), .full(q_full), .empty(q_empty)
	);

	pkop_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .KEY_SLOTS(KEY_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .job(head_job), .empty(q_empty), .pop(pop),
		.result(result), .strobe(strobe)
	);

`ifndef SYNTHESIS
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.none_found |-> result.last)
		else $error("none result not marked last");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.none_found |-> result.candidate == 16'd0)
		else $error("none result carries a candidate");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe && !result.none_found)
		else $error("query results not contiguous");
`endif

endmodule

### hdl/pkop_front.sv
// Front end: accepts commands, keeps per-key metadata (pointer, fill, present,
// disabled) in a memory, and issues jobs to the back end. Uses pkop_pkg.
module pkop_front #(
	parameter int HISTORY_DEPTH = pkop_pkg::HISTORY_DEPTH_DEF,
	parameter int KEY_SLOTS     = pkop_pkg::KEY_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pkop_pkg::cmd_t cmd,
	output logic          busy,
	output pkop_pkg::job_t job,
	output logic          push,
	input  logic          q_full
);
	import pkop_pkg::*;

	localparam int KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int MW = PW + 3;
	localparam int M_PRES = MW - 1;
	localparam int M_DIS  = MW - 2;
	localparam int M_FULL = MW - 3;

	logic [MW-1:0] meta_mem [KEY_SLOTS];

	front_state_t state_q, state_d;
	logic [KW-1:0] clr_q;
	cmd_t          cmd_q;
	logic [MW-1:0] meta_q;

	logic          accept, in_range, need_push, done;
	logic          meta_we;
	logic [KW-1:0] meta_wa;
	logic [MW-1:0] meta_wd;
	logic [PW-1:0] ptr, ptr_nxt;
	logic          wrap;

	assign accept   = start && !busy;
	assign busy     = (state_q != F_IDLE);
	assign in_range = (int'(cmd_q.key_index) < KEY_SLOTS);
	assign ptr      = meta_q[PW-1:0];
	assign wrap     = (ptr == PW'(HISTORY_DEPTH - 1));
	assign ptr_nxt  = wrap ? '0 : ptr + PW'(1);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_CLEAR)
				clr_q <= clr_q + KW'(1);
		end
	end

	// Command capture and metadata memory
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			meta_q <= meta_mem[KW'(cmd.key_index)];
		end
		if (meta_we)
			meta_mem[meta_wa] <= meta_wd;
	end

	// Next state, metadata update and job issue
	always_comb begin
		state_d      = state_q;
		meta_we      = 1'b0;
		meta_wa      = KW'(cmd_q.key_index);
		meta_wd      = meta_q;
		need_push    = 1'b0;
		done         = 1'b0;
		job.kind     = JOB_NONE;
		job.key      = KEY_W_MAX'(cmd_q.key_index);
		job.slot     = SLOT_W_MAX'(ptr);
		job.full     = meta_q[M_FULL];
		job.ordinal  = cmd_q.ordinal;
		case (state_q)
			F_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				meta_wd = '0;
				if (clr_q == KW'(KEY_SLOTS - 1))
					state_d = F_IDLE;
			end
			F_IDLE: begin
				if (accept)
					state_d = F_ACT;
			end
			F_ACT: begin
				case (cmd_q.opcode)
					OP_RECORD: begin
						if (in_range) begin
							need_push         = 1'b1;
							job.kind          = JOB_RECORD;
							meta_we           = 1'b1;
							meta_wd[PW-1:0]   = ptr_nxt;
							meta_wd[M_FULL]   = meta_q[M_FULL] | wrap;
							meta_wd[M_PRES]   = 1'b1;
						end
					end
					OP_QUERY: begin
						need_push = 1'b1;
						if (in_range && meta_q[M_PRES] && !meta_q[M_DIS])
							job.kind = JOB_QUERY;
					end
					OP_DISABLE: begin
						if (in_range && meta_q[M_PRES]) begin
							meta_we        = 1'b1;
							meta_wd[M_DIS] = 1'b1;
						end
					end
					default: ;
				endcase
				done = !need_push || !q_full;
				if (!done)
					meta_we = 1'b0;
				else
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
		push = (state_q == F_ACT) && need_push && !q_full;
	end

endmodule

### hdl/pkop_queue.sv
// Job queue between front and back end: small register FIFO.
// Uses pkop_pkg.
module pkop_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pkop_pkg::job_t wr_job,
	input  logic           pop,
	output pkop_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import pkop_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);

	job_t          slots_q [QUEUE_DEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0]   cnt_q;

	assign full  = (cnt_q == (QW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slots_q[rp_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + QW'(1);
			if (pop)
				rp_q <= rp_q + QW'(1);
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wp_q] <= wr_job;
	end

endmodule

### hdl/pkop_back.sv
// Back end: ring memory writes for records, and the query engine that loads a
// key's ring, counts and ranks ordinals, and emits candidates. Uses pkop_pkg.
module pkop_back #(
	parameter int HISTORY_DEPTH = pkop_pkg::HISTORY_DEPTH_DEF,
	parameter int KEY_SLOTS     = pkop_pkg::KEY_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pkop_pkg::job_t    job,
	input  logic              empty,
	output logic              pop,
	output pkop_pkg::result_t result,
	output logic              strobe
);
	import pkop_pkg::*;

	localparam int D  = HISTORY_DEPTH;
	localparam int PW = $clog2(D);
	localparam int RW = PW + 1;
	localparam int CW = $clog2(D + 1);
	localparam int AW = $clog2(KEY_SLOTS * D);

	logic [15:0] ring_mem [KEY_SLOTS * D];

	back_state_t state_q, state_d;
	logic [KEY_W_MAX-1:0] key_q;
	logic [PW-1:0]  ptr_q;
	logic           full_q;
	logic [PW:0]    lcnt_q;
	logic           rd_vld_q;
	logic [PW-1:0]  rd_slot_q;
	logic [15:0]    rd_data_q;
	logic [15:0]    line_q [D];
	logic [D-1:0]   match_s1;
	logic [PW-1:0]  idx_q;
	logic [15:0]    strong_q [MAX_OUT];
	logic [15:0]    weak_q [MAX_OUT];
	logic [PW-1:0]  wrank_q [MAX_OUT];
	logic [2:0]     ns_q, nw_q, emit_q;
	result_t        result_q, res_d;
	logic           strobe_q, strb_d;

	logic           ring_we, ring_re;
	logic [AW-1:0]  ring_wa, ring_ra;

	// Evaluation of the ordinal at the head of the line
	logic [15:0]    cur;
	logic           seen;
	logic [CW-1:0]  cnt;
	logic [PW-1:0]  hj;
	logic [RW-1:0]  last_idx, rank;
	logic           is_strong, is_weak;
	logic [2:0]     spos, wpos;
	logic [3:0]     sum;
	logic [2:0]     tot;

	assign result = result_q;
	assign strobe = strobe_q;
	assign pop    = (state_q == B_IDLE) && !empty;

	assign ring_we = pop && (job.kind == JOB_RECORD);
	assign ring_wa = AW'(int'(job.key) * D + int'(job.slot));
	assign ring_re = (state_q == B_LOAD) && (int'(lcnt_q) < D);
	assign ring_ra = AW'(int'(key_q) * D + int'(lcnt_q));

	// Ring memory
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= job.ordinal;
		if (ring_re)
			rd_data_q <= ring_mem[ring_ra];
	end

	// Count matches, find last occurrence, rank and insertion points
	always_comb begin
		cur  = line_q[0];
		seen = 1'b0;
		cnt  = '0;
		hj   = '0;
		for (int j = 0; j < D; j++) begin
			if (match_s1[j]) begin
				if (j >= D - int'(idx_q)) begin
					seen = 1'b1;
				end else begin
					cnt = cnt + CW'(1);
					hj  = PW'(j);
				end
			end
		end
		last_idx = RW'(idx_q) + RW'(hj);
		rank     = RW'(ptr_q) + RW'(D) - last_idx;
		if (rank >= RW'(D))
			rank = rank - RW'(D);
		is_strong = (cur != NOT_FOUND) && !seen && (cnt >= CW'(STRONG_COUNT));
		is_weak   = (cur != NOT_FOUND) && !seen && (cnt >= CW'(WEAK_COUNT)) &&
		            (cnt < CW'(STRONG_COUNT));
		spos = '0;
		wpos = '0;
		for (int m = 0; m < MAX_OUT; m++) begin
			if (3'(m) < ns_q && strong_q[m] < cur)
				spos = spos + 3'(1);
			if (3'(m) < nw_q && RW'(wrank_q[m]) > rank)
				wpos = wpos + 3'(1);
		end
		sum = {1'b0, ns_q} + {1'b0, nw_q};
		tot = (sum > 4'(MAX_OUT)) ? 3'(MAX_OUT) : sum[2:0];
	end

	// Next state and result
	always_comb begin
		state_d = state_q;
		res_d   = '0;
		strb_d  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					if (job.kind == JOB_QUERY)
						state_d = B_LOAD;
					else if (job.kind == JOB_NONE) begin
						strb_d           = 1'b1;
						res_d.none_found = 1'b1;
						res_d.last       = 1'b1;
					end
				end
			end
			B_LOAD: begin
				if (int'(lcnt_q) == D)
					state_d = B_CMP;
			end
			B_CMP: state_d = B_EVAL;
			B_EVAL: begin
				if (idx_q == PW'(D - 1))
					state_d = B_EMIT;
				else
					state_d = B_CMP;
			end
			B_EMIT: begin
				strb_d = 1'b1;
				if (tot == '0) begin
					res_d.none_found = 1'b1;
					res_d.last       = 1'b1;
					state_d          = B_IDLE;
				end else begin
					res_d.candidate = (emit_q < ns_q) ? strong_q[emit_q]
					                                  : weak_q[emit_q - ns_q];
					if (emit_q == tot - 3'(1)) begin
						res_d.last = 1'b1;
						state_d    = B_IDLE;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strb_d;
			rd_vld_q <= ring_re;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		result_q  <= res_d;
		rd_slot_q <= PW'(lcnt_q);
		case (state_q)
			B_IDLE: begin
				key_q  <= job.key;
				ptr_q  <= PW'(job.slot);
				full_q <= job.full;
				lcnt_q <= '0;
				idx_q  <= '0;
				ns_q   <= '0;
				nw_q   <= '0;
				emit_q <= '0;
			end
			B_LOAD: begin
				if (ring_re)
					lcnt_q <= lcnt_q + (PW+1)'(1);
				// unwritten slots read as not found
				if (rd_vld_q) begin
					for (int j = 0; j < D - 1; j++)
						line_q[j] <= line_q[j+1];
					line_q[D-1] <= (full_q || rd_slot_q < ptr_q) ? rd_data_q : NOT_FOUND;
				end
			end
			B_CMP: begin
				for (int j = 0; j < D; j++)
					match_s1[j] <= (line_q[j] == line_q[0]);
			end
			B_EVAL: begin
				// rotate so the next ring slot sits at the head
				for (int j = 0; j < D - 1; j++)
					line_q[j] <= line_q[j+1];
				line_q[D-1] <= line_q[0];
				idx_q <= idx_q + PW'(1);
				if (is_strong) begin
					for (int m = 0; m < MAX_OUT; m++) begin
						if (3'(m) == spos)
							strong_q[m] <= cur;
						else if (3'(m) > spos)
							strong_q[m] <= strong_q[(m > 0) ? m - 1 : 0];
					end
					if (ns_q < 3'(MAX_OUT))
						ns_q <= ns_q + 3'(1);
				end
				if (is_weak) begin
					for (int m = 0; m < MAX_OUT; m++) begin
						if (3'(m) == wpos) begin
							weak_q[m]  <= cur;
							wrank_q[m] <= PW'(rank);
						end else if (3'(m) > wpos) begin
							weak_q[m]  <= weak_q[(m > 0) ? m - 1 : 0];
							wrank_q[m] <= wrank_q[(m > 0) ? m - 1 : 0];
						end
					end
					if (nw_q < 3'(MAX_OUT))
						nw_q <= nw_q + 3'(1);
				end
			end
			B_EMIT: emit_q <= emit_q + 3'(1);
			default: ;
		endcase
	end

endmodule
